FILE: hw/rtl/srti_pkg.sv
// Package for the sorted range table intersect block.
// Holds the transfer structs, item kind and status codes and the table entry type.
// No dependencies; used by sorted_range_table_intersect_top.
`timescale 1ns / 1ps

package srti_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  // Item kinds.
  localparam logic [1:0] KIND_CLEAR     = 2'd0;
  localparam logic [1:0] KIND_INSERT    = 2'd1;
  localparam logic [1:0] KIND_INTERSECT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] range_begin;
    logic [31:0] range_length;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] common_begin;
    logic [31:0] common_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] range_begin;
    logic [31:0] range_length;
  } entry_t;

  // A result held back until it is known whether it is the final one.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] common_begin;
    logic [31:0] common_length;
  } pend_t;

endpackage

FILE: hw/rtl/sorted_range_table_intersect_top.sv
// Sorted range table with streaming intersection: top level.
// Holds the sequencer, the single-port range table memory and the output register.
// Depends on srti_pkg.
`timescale 1ns / 1ps

// The block works on one item at a time and stalls its input while busy. All table
// accesses go through one memory with one read or write port a cycle and registered
// read data, and that port sets the timing. An insert into a table that is not full
// does a binary search, moves each entry behind the insertion point up by one and
// writes the new entry. An intersect walks the table from the cursor, and one result
// is handed over per walked entry with a common range. A result that waits on a
// stalled output holds the block. A full table returns status 1 and is left
// unchanged; kind 3 is accepted and dropped without a result. There is no clearing
// pass after reset: the entry count starts at zero.
module sorted_range_table_intersect_top #(
  parameter int unsigned TABLE_DEPTH = srti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srti_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srti_pkg::out_item_t out_item_o
);
  import srti_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH     = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_SH_RD    = 4'd3;
  localparam logic [3:0] S_SH_WR    = 4'd4;
  localparam logic [3:0] S_INS_WR   = 4'd5;
  localparam logic [3:0] S_INT_RD   = 4'd6;
  localparam logic [3:0] S_INT_SUM  = 4'd7;
  localparam logic [3:0] S_INT_CMP  = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0]    state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] cursor_q;
  logic [CW-1:0] lo_q;
  logic [CW-1:0] hi_q;
  logic [CW-1:0] idx_q;
  logic [31:0]   qb_q;
  logic [31:0]   ql_q;
  logic [32:0]   qend_q;
  logic [32:0]   eend_q;
  logic [31:0]   cb_q;
  logic          pend_valid_q;
  pend_t         pend_q;
  logic          out_valid_q;
  out_item_t     out_q;

  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic          accept;
  logic          out_free;
  logic          push_en;
  out_item_t     push_item;
  logic [CW-1:0] mid;
  logic [CW-1:0] idx_m1;
  logic [32:0]   ce;
  logic [31:0]   clen;
  logic          nonempty;
  logic          cmp_hold;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_m1   = idx_q - 1'b1;
  assign ce       = (eend_q < qend_q) ? eend_q : qend_q;
  assign nonempty = ({1'b0, cb_q} < ce);
  assign clen     = 32'(ce - {1'b0, cb_q});
  // A new common range can only be taken once the held one has somewhere to go.
  assign cmp_hold = nonempty && pend_valid_q && !out_free;

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_q;
    push_en   = 1'b0;
    push_item = '{status: pend_q.status, common_begin: pend_q.common_begin,
                  common_length: pend_q.common_length, last: 1'b0};
    unique case (state_q)
      S_SRCH: begin
        rd_en   = (lo_q < hi_q);
        rd_addr = mid[AW-1:0];
      end
      S_SH_RD: begin
        rd_en   = (idx_q > lo_q);
        rd_addr = idx_m1[AW-1:0];
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = lo_q[AW-1:0];
        wr_data = '{range_begin: qb_q, range_length: ql_q};
      end
      S_INT_RD: begin
        rd_en   = (cursor_q < count_q);
        rd_addr = cursor_q[AW-1:0];
      end
      S_INT_CMP: begin
        push_en = nonempty && pend_valid_q && out_free;
      end
      S_FIN: begin
        push_en = out_free;
        if (pend_valid_q) begin
          push_item.last = 1'b1;
        end else begin
          push_item = '{status: ST_NONE, common_begin: '0, common_length: '0, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cursor_q     <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      idx_q        <= '0;
      qb_q         <= '0;
      ql_q         <= '0;
      qend_q       <= '0;
      eend_q       <= '0;
      cb_q         <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (push_en) begin
        out_valid_q <= 1'b1;
        out_q       <= push_item;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            qb_q   <= in_item_i.range_begin;
            ql_q   <= in_item_i.range_length;
            qend_q <= {1'b0, in_item_i.range_begin} + {1'b0, in_item_i.range_length};
            case (in_item_i.kind)
              KIND_CLEAR: begin
                count_q      <= '0;
                cursor_q     <= '0;
                pend_q       <= '{status: ST_OK, common_begin: '0, common_length: '0};
                pend_valid_q <= 1'b1;
                state_q      <= S_FIN;
              end
              KIND_INSERT: begin
                if (count_q >= CW'(TABLE_DEPTH)) begin
                  pend_q       <= '{status: ST_FULL, common_begin: '0, common_length: '0};
                  pend_valid_q <= 1'b1;
                  state_q      <= S_FIN;
                end else begin
                  lo_q    <= '0;
                  hi_q    <= count_q;
                  state_q <= S_SRCH;
                end
              end
              KIND_INTERSECT: begin
                if (in_item_i.restart) begin
                  cursor_q <= '0;
                end
                pend_valid_q <= 1'b0;
                state_q      <= S_INT_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo_q < hi_q) begin
            state_q <= S_SRCH_CMP;
          end else begin
            idx_q   <= count_q;
            state_q <= S_SH_RD;
          end
        end
        S_SRCH_CMP: begin
          // Lower bound: equal begins land before the existing entries.
          if (rd_q.range_begin < qb_q) begin
            lo_q <= mid + 1'b1;
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_SH_RD: begin
          state_q <= (idx_q > lo_q) ? S_SH_WR : S_INS_WR;
        end
        S_SH_WR: begin
          idx_q   <= idx_m1;
          state_q <= S_SH_RD;
        end
        S_INS_WR: begin
          count_q      <= count_q + 1'b1;
          pend_q       <= '{status: ST_OK, common_begin: '0, common_length: '0};
          pend_valid_q <= 1'b1;
          state_q      <= S_FIN;
        end
        S_INT_RD: begin
          state_q <= (cursor_q < count_q) ? S_INT_SUM : S_FIN;
        end
        S_INT_SUM: begin
          eend_q  <= {1'b0, rd_q.range_begin} + {1'b0, rd_q.range_length};
          cb_q    <= (rd_q.range_begin > qb_q) ? rd_q.range_begin : qb_q;
          state_q <= S_INT_CMP;
        end
        S_INT_CMP: begin
          if (!cmp_hold) begin
            if (nonempty) begin
              pend_q       <= '{status: ST_OK, common_begin: cb_q,
                                common_length: clen};
              pend_valid_q <= 1'b1;
            end
            // Advance past an entry that ends no later than the query range.
            if (eend_q <= qend_q) begin
              cursor_q <= cursor_q + 1'b1;
            end
            state_q <= (eend_q < qend_q) ? S_INT_RD : S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: bench/sorted_range_table_intersect_top_test.sv
// Self-checking bench for sorted_range_table_intersect_top: directed items, then sequences
// of clears, inserts and sorted query lists; both channels idle at random until the last
// phase. Depends on srti_pkg and the top level; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module sorted_range_table_intersect_top_test;
  import srti_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 138;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Scoreboard: keeps its own copy of the range table and queues what each item should
  // produce.
  class intersect_scoreboard;
    logic [31:0] tab_begin [TABLE_DEPTH];
    logic [31:0] tab_len [TABLE_DEPTH];
    int unsigned n_entries = 0;
    int unsigned cursor = 0;
    out_item_t due_results [$];
    int unsigned errors = 0;

    function automatic out_item_t make_result(logic [1:0] st, logic [31:0] cb,
                                              logic [31:0] cl, logic lst);
      out_item_t r;
      r.status = st;
      r.common_begin = cb;
      r.common_length = cl;
      r.last = lst;
      return r;
    endfunction

    function automatic logic [1:0] add_entry(logic [31:0] rb, logic [31:0] rl);
      int unsigned lo, hi, mid, i;
      if (n_entries >= TABLE_DEPTH) return ST_FULL;
      lo = 0;
      hi = n_entries;
      // Lower bound: equal begins land in front of the entries already there.
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tab_begin[mid] < rb) lo = mid + 1;
        else hi = mid;
      end
      for (i = n_entries; i > lo; i--) begin
        tab_begin[i] = tab_begin[i - 1];
        tab_len[i] = tab_len[i - 1];
      end
      tab_begin[lo] = rb;
      tab_len[lo] = rl;
      n_entries++;
      return ST_OK;
    endfunction

    function automatic void intersect_range(logic [31:0] qb, logic [31:0] ql);
      logic [32:0] qend, eend, cb, ce, diff;
      out_item_t found [$];
      out_item_t tail;
      qend = {1'b0, qb} + {1'b0, ql};
      while (cursor < n_entries) begin
        eend = {1'b0, tab_begin[cursor]} + {1'b0, tab_len[cursor]};
        cb = (tab_begin[cursor] > qb) ? {1'b0, tab_begin[cursor]} : {1'b0, qb};
        ce = (eend < qend) ? eend : qend;
        if (cb < ce) begin
          diff = ce - cb;
          found.push_back(make_result(ST_OK, cb[31:0], diff[31:0], 1'b0));
        end
        if (eend < qend) begin
          cursor++;
        end else if (eend > qend) begin
          break;
        end else begin
          cursor++;
          break;
        end
      end
      if (found.size() == 0) begin
        due_results.push_back(make_result(ST_NONE, '0, '0, 1'b1));
      end else begin
        tail = found.pop_back();
        tail.last = 1'b1;
        found.push_back(tail);
        foreach (found[k]) due_results.push_back(found[k]);
      end
    endfunction

    function automatic void take_item(in_item_t it);
      case (it.kind)
        KIND_CLEAR: begin
          n_entries = 0;
          cursor = 0;
          due_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
        KIND_INSERT: begin
          due_results.push_back(make_result(add_entry(it.range_begin, it.range_length),
                                            '0, '0, 1'b1));
        end
        KIND_INTERSECT: begin
          if (it.restart) cursor = 0;
          intersect_range(it.range_begin, it.range_length);
        end
        default: ;
      endcase
    endfunction

    function automatic void report(string field, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, e, g);
      errors++;
    endfunction

    function automatic void check_result(out_item_t got);
      out_item_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (got.status !== e.status) report("status", 32'(e.status), 32'(got.status));
      if (got.common_begin !== e.common_begin)
        report("common_begin", e.common_begin, got.common_begin);
      if (got.common_length !== e.common_length)
        report("common_length", e.common_length, got.common_length);
      if (got.last !== e.last) report("last", 32'(e.last), 32'(got.last));
    endfunction

    function automatic int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  intersect_scoreboard sb = new();
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned items_sent;
  int unsigned cycle_count;

  sorted_range_table_intersect_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.take_item(in_item_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_range(input logic [1:0] kind, input logic [31:0] rb,
                            input logic [31:0] rl, input logic rs);
    in_item_t it;
    it.kind = kind;
    it.range_begin = rb;
    it.range_length = rl;
    it.restart = rs;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Stray items: dropped kinds and intersects that ignore the current query list.
  task automatic send_noise();
    send_range($urandom_range(1) ? KIND_UNUSED : KIND_INTERSECT, $urandom, $urandom,
               1'($urandom_range(1)));
  endtask

  // An optional clear, a batch of inserts and a sorted, non-overlapping query list.
  task automatic run_sequence(input bit fill);
    int unsigned mode, n_ins, n_q, i;
    logic [31:0] base, span, rb, rl;
    logic [32:0] pos, nb;
    mode = $urandom_range(9);
    if (mode < 6) begin
      base = 32'd0;
      span = 32'd2000;
    end else if (mode < 8) begin
      // Ranges near the top of the address space, so that ends need the 33rd bit.
      base = 32'hFFFF_F800;
      span = 32'd2000;
    end else begin
      base = 32'd0;
      span = 32'hFFFF_FFFF;
    end
    if ($urandom_range(4) != 0)
      send_range(KIND_CLEAR, $urandom, $urandom, 1'($urandom_range(1)));
    n_ins = fill ? $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH - 2) : $urandom_range(12, 1);
    for (i = 0; i < n_ins; i++) begin
      if (mode >= 8) begin
        rb = $urandom;
        rl = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0FFF_FFFF);
      end else begin
        rb = base + $urandom_range(span);
        rl = ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(span / 4);
      end
      send_range(KIND_INSERT, rb, rl, 1'($urandom_range(1)));
      if ($urandom_range(14) == 0) send_noise();
    end
    n_q = $urandom_range(8, 1);
    pos = {1'b0, base} + $urandom_range(span / 8);
    for (i = 0; i < n_q; i++) begin
      nb = pos + $urandom_range(span / 8);
      if (nb[32]) break;
      rl = $urandom_range(span / 3);
      send_range(KIND_INTERSECT, nb[31:0], rl, (i == 0) ^ ($urandom_range(19) == 0));
      pos = nb + rl;
      if ($urandom_range(14) == 0) send_noise();
    end
  endtask

  initial begin
    int unsigned phase, start_items;
    bit first;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    items_sent = 0;
    src_idle_pct = 33;
    sink_stall_pct = 70;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, extremes, zero lengths, equal begins, ends past 32 bits.
    send_range(KIND_INTERSECT, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_range(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_range(KIND_INSERT, 32'd0, 32'd0, 1'b1);
    send_range(KIND_INSERT, 32'd100, 32'd50, 1'b0);
    send_range(KIND_INSERT, 32'd100, 32'd10, 1'b0);
    send_range(KIND_INSERT, 32'd140, 32'd60, 1'b0);
    send_range(KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_range(KIND_INTERSECT, 32'd0, 32'd120, 1'b1);
    send_range(KIND_INTERSECT, 32'd130, 32'd20, 1'b0);
    send_range(KIND_INTERSECT, 32'd150, 32'd0, 1'b0);
    send_range(KIND_INTERSECT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    send_range(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_range(KIND_INTERSECT, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_range(KIND_INTERSECT, 32'd5, 32'd5, 1'b0);
    send_range(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_range(KIND_INTERSECT, 32'd0, 32'd0, 1'b0);
    start_items = items_sent;

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct = 70;
        sink_stall_pct = 33;
      end else if (phase == 2) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      // Let the block run dry before items are sent under the new idling pattern.
      if (phase > 0) wait_for_results();
      first = 1'b1;
      while (items_sent < start_items + (phase + 1) * PHASE_ITEMS) begin
        run_sequence((first && phase == 0) || $urandom_range(5) == 0);
        first = 1'b0;
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
